FILE: hdl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// shared types and codes for the best-fit heap allocator
// ----------------------------------------------------------------------------
package bfha_pkg;

	localparam int HEAP_ADDR_BITS = 25;
	localparam int FIELD_BITS = HEAP_ADDR_BITS;
	localparam int HDR_BITS   = 8;
	localparam int CFG_BITS   = 25;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_REINIT = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic REG_HEAP_BYTES   = 1'b0;
	localparam logic REG_HEADER_BYTES = 1'b1;

	localparam logic [FIELD_BITS-1:0] HEAP_RESET   = 25'd32505856;
	localparam logic [HDR_BITS-1:0]   HEADER_RESET = 8'd16;

	typedef struct packed {
		logic [1:0]            operation;
		logic [FIELD_BITS-1:0] request_bytes;
		logic [FIELD_BITS-1:0] release_address;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [FIELD_BITS-1:0] address;
	} rsp_t;

	// shared adder controls
	typedef enum logic [1:0] {
		ADD_AB, ADD_ABH, ADD_AMB
	} add_op_t;

endpackage

FILE: hdl/bfha_alu.sv
// ----------------------------------------------------------------------------
// bfha_alu
// shared saturating add, wrapping subtract and compare unit
// ----------------------------------------------------------------------------
module bfha_alu #(
	parameter int W = 25
) (
	input  bfha_pkg::add_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	input  logic [7:0]        h,
	output logic [W-1:0]      sum,
	output logic              a_ge_b
);
	import bfha_pkg::*;

	logic [W+1:0] wide;

	always_comb begin
		case (op)
			ADD_AB:  wide = {2'b0, a} + {2'b0, b};
			ADD_ABH: wide = {2'b0, a} + {2'b0, b} + (W+2)'(h);
			default: wide = {2'b0, a} - {2'b0, b};
		endcase
		if (op == ADD_AMB) sum = wide[W-1:0];
		else if (wide[W+1:W] != 2'b0) sum = '1;
		else sum = wide[W-1:0];
		a_ge_b = (a >= b);
	end

endmodule

FILE: hdl/bfha_table.sv
// ----------------------------------------------------------------------------
// bfha_table
// segment table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfha_table #(
	parameter int W  = 25,
	parameter int AW = 6,
	parameter int N  = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W:0]    wdata_start_used,
	input  logic [W-1:0]  wdata_size,
	input  logic [AW-1:0] raddr,
	output logic [W:0]    rdata_start_used,
	output logic [W-1:0]  rdata_size
);
	logic [2*W:0] mem [N];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= {wdata_start_used, wdata_size};
		{rdata_start_used, rdata_size} <= mem[raddr];
	end

endmodule

FILE: hdl/best_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top
// best-fit heap allocator with free-neighbor coalescing
// ----------------------------------------------------------------------------
// usage
//   req_valid/req_ready carry one request: allocate, free or reinitialize
//   rsp_valid/rsp_ready return one response per request (status, address)
//   cfg_we/cfg_index/cfg_data write heap_bytes (0) or header_bytes (1);
//   heap_bytes is used at the next reinitialize, header_bytes at once
// sequencing
//   one request at a time; the table sits in a memory with a registered
//   read port, so each entry visited is first read, then evaluated
//   allocate: a scan of every entry, then on a split a top-down shift
//   and the split write; free: one lookup/compact pass plus a step per merge
//   reinitialize: stale entries beyond the count are ignored
// reset
//   after arst_n the S_INIT state writes the single free segment, then ready rises
// stall
//   the response is held in an output register; the block takes no new
//   request until that response has been taken
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_top #(
	parameter int MAX_SEGMENTS   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bfha_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output bfha_pkg::rsp_t   rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [24:0]      cfg_data
);
	import bfha_pkg::*;

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int W  = FIELD_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SPLIT_RD, S_SHIFT_RD, S_SHIFT_WR,
		S_SPLIT_WR, S_SPLIT_FIX, S_FREE_RD, S_FREE_EV, S_MERGE_WR, S_RESP,
		S_FREE_END, S_INIT
	} state_t;

	state_t state_q;

	logic [W-1:0]  heap_q;
	logic [7:0]    hdr_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    op_q;
	logic [W-1:0]  reqb_q, rel_q;
	logic [W-1:0]  best_q;
	logic          found_q;
	logic [AW-1:0] pick_q;
	logic [W-1:0]  pstart_q, psize_q;
	logic [CW-1:0] wr_q;       // compaction write pointer
	logic          hit_q;
	logic [W-1:0]  rstart_q, rsize_q;   // pending entry waiting to be written at wr_q
	logic          rused_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	// free pass decode of the entry just read
	logic          fr_hit, fr_used, fr_merge;

	// table ports
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [W:0]    wsu, rsu;
	logic [W-1:0]  wsz, rsz;

	bfha_table #(.W(W), .AW(AW), .N(MAX_SEGMENTS)) u_table (
		.clk, .we, .waddr, .wdata_start_used(wsu), .wdata_size(wsz),
		.raddr, .rdata_start_used(rsu), .rdata_size(rsz)
	);

	wire [W-1:0] r_start = rsu[W:1];
	wire         r_used  = rsu[0];

	// shared arithmetic unit
	add_op_t       aop;
	logic [W-1:0]  aa, ab, asum;
	logic          age;

	bfha_alu #(.W(W)) u_alu (
		.op(aop), .a(aa), .b(ab), .h(hdr_q), .sum(asum), .a_ge_b(age)
	);

	// need = request + header, computed once and kept one bit wider than a
	// size; its carry bit marks a need above 2^W-1, which no segment can meet
	logic [W:0] need;
	assign need = {1'b0, reqb_q} + (W+1)'(hdr_q);

	// operand steering
	always_comb begin
		aop = ADD_ABH; aa = r_start; ab = '0;
		unique case (state_q)
			S_SPLIT_WR:  begin aop = ADD_ABH; aa = pstart_q; ab = reqb_q; end
			S_SPLIT_FIX: begin aop = ADD_ABH; aa = pstart_q; ab = '0; end
			S_MERGE_WR:  begin aop = ADD_ABH; aa = rsize_q; ab = rsz; end
			S_FREE_EV:   begin aop = ADD_ABH; aa = r_start; ab = '0; end
			S_IDLE:      begin aop = ADD_AMB; aa = heap_q; ab = W'(hdr_q); end
			S_INIT:      begin aop = ADD_AMB; aa = heap_q; ab = W'(hdr_q); end
			default:     begin aop = ADD_ABH; aa = pstart_q; ab = '0; end
		endcase
	end

	// data offset match, first hit only; a hit entry counts as free
	always_comb begin
		fr_hit   = !hit_q && (asum == rel_q);
		fr_used  = fr_hit ? 1'b0 : r_used;
		fr_merge = (idx_q != '0) && !fr_used && !rused_q;
	end

	// memory read address
	always_comb begin
		raddr = idx_q[AW-1:0];
	end

	// memory write
	always_comb begin
		we = 1'b0; waddr = idx_q[AW-1:0]; wsu = '0; wsz = '0;
		unique case (state_q)
			S_SHIFT_WR: begin
				we = 1'b1; waddr = AW'(idx_q + 1'b1); wsu = rsu; wsz = rsz;
			end
			S_SPLIT_WR: begin
				we = 1'b1; waddr = AW'(pick_q + 1'b1);
				wsu = {asum, 1'b0}; wsz = psize_q - need[W-1:0];
			end
			S_SPLIT_FIX: begin
				we = 1'b1; waddr = pick_q; wsu = {pstart_q, 1'b1};
				wsz = (psize_q > need[W-1:0] || need[W]) ? reqb_q : psize_q;
			end
			S_FREE_EV: begin
				// compact: flush the pending entry unless this one merges into it
				if (idx_q != '0 && !fr_merge) begin
					we = 1'b1; waddr = wr_q[AW-1:0];
					wsu = {rstart_q, rused_q}; wsz = rsize_q;
				end
			end
			S_FREE_END: begin
				we = 1'b1; waddr = wr_q[AW-1:0];
				wsu = {rstart_q, rused_q}; wsz = rsize_q;
			end
			S_IDLE: begin
				we = req_valid && req_ready && req.operation == OP_REINIT;
				waddr = '0; wsu = '0;
				wsz = (heap_q > W'(hdr_q)) ? asum : '0;
			end
			S_INIT: begin
				we = 1'b1; waddr = '0; wsu = '0;
				wsz = (heap_q > W'(hdr_q)) ? asum : '0;
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			heap_q      <= HEAP_RESET;
			hdr_q       <= HEADER_RESET;
			count_q     <= CW'(1);
			op_q        <= OP_REINIT;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			hit_q       <= 1'b0;
			wr_q        <= '0;
			pick_q      <= '0;
			best_q      <= '0;
			reqb_q <= '0; rel_q <= '0; pstart_q <= '0; psize_q <= '0;
			rstart_q <= '0; rsize_q <= '0; rused_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_HEAP_BYTES) heap_q <= cfg_data;
				else hdr_q <= cfg_data[7:0];
			end
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				// one free segment covering the heap
				S_INIT: begin
					count_q <= CW'(1);
					state_q <= S_IDLE;
				end
				S_IDLE: if (req_valid && req_ready) begin
					op_q   <= req.operation;
					reqb_q <= req.request_bytes;
					rel_q  <= req.release_address;
					idx_q  <= '0;
					found_q <= 1'b0;
					best_q <= '1;
					hit_q  <= 1'b0;
					wr_q   <= '0;
					rsp_q  <= '{status: ST_OK, address: '0};
					unique case (req.operation)
						OP_ALLOC:  state_q <= S_SCAN_RD;
						OP_FREE:   state_q <= S_FREE_RD;
						OP_REINIT: begin count_q <= CW'(1); state_q <= S_RESP; end
						default:   state_q <= S_RESP;
					endcase
				end
				// ---- allocate: best-fit scan
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (!r_used && !need[W] && rsz >= need[W-1:0] && rsz <= best_q) begin
						best_q <= rsz; pick_q <= idx_q[AW-1:0];
						pstart_q <= r_start; psize_q <= rsz; found_q <= 1'b1;
					end
					if (idx_q + 1'b1 < count_q) begin
						idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_SPLIT_RD;
					end
				end
				S_SPLIT_RD: begin
					if (!found_q && !(!r_used && !need[W] && rsz >= need[W-1:0]
						&& rsz <= best_q)) begin
						rsp_q.status <= ST_NOFIT; state_q <= S_RESP;
					end else if (psize_q > need[W-1:0]) begin
						if (count_q >= CW'(MAX_SEGMENTS)) begin
							rsp_q.status <= ST_FULL; state_q <= S_RESP;
						end else begin
							idx_q <= count_q - 1'b1;
							state_q <= (count_q - 1'b1 > CW'(pick_q)) ? S_SHIFT_RD
								: S_SPLIT_WR;
						end
					end else begin
						state_q <= S_SPLIT_FIX;
					end
				end
				// shift entries above pick up by one, from the top down
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					if (idx_q - 1'b1 > CW'(pick_q)) begin
						idx_q <= idx_q - 1'b1; state_q <= S_SHIFT_RD;
					end else begin
						state_q <= S_SPLIT_WR;
					end
				end
				S_SPLIT_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_SPLIT_FIX;
				end
				// data offset of the chosen segment
				S_SPLIT_FIX: begin
					rsp_q.address <= asum;
					state_q <= S_RESP;
				end
				// ---- free: lookup and compact in one pass, free runs collapse
				// into their first entry; with no hit nothing moves
				S_FREE_RD: state_q <= S_FREE_EV;
				S_FREE_EV: begin
					if (fr_hit) hit_q <= 1'b1;
					if (fr_merge) begin
						state_q <= S_MERGE_WR;
					end else begin
						if (idx_q != '0) wr_q <= wr_q + 1'b1;
						rstart_q <= r_start; rsize_q <= rsz; rused_q <= fr_used;
						if (idx_q + 1'b1 < count_q) begin
							idx_q <= idx_q + 1'b1; state_q <= S_FREE_RD;
						end else begin
							state_q <= S_FREE_END;
						end
					end
				end
				// absorb the entry just read into the pending run head
				S_MERGE_WR: begin
					rsize_q <= asum;
					if (idx_q + 1'b1 < count_q) begin
						idx_q <= idx_q + 1'b1; state_q <= S_FREE_RD;
					end else begin
						state_q <= S_FREE_END;
					end
				end
				S_FREE_END: begin
					count_q <= wr_q + 1'b1;
					if (!hit_q) rsp_q.status <= ST_UNKNOWN;
					state_q <= S_RESP;
				end
				default: ;
			endcase
			if (state_q == S_RESP && !rsp_valid_q) begin
				rsp_valid_q <= 1'b1;
				if (op_q != OP_ALLOC) rsp_q.address <= '0;
				state_q <= S_IDLE;
			end
		end
	end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives allocate, free and reinitialize requests into the best-fit heap
// allocator, predicts each response from a private copy of the segment table
// and compares status and address field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import bfha_pkg::*;

	localparam int NSEG      = 64;
	localparam logic [24:0] ADDR_SAT = 25'h1FFFFFF;
	localparam int CYCLE_LIMIT = 2000000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_ready;
	req_t   req = '0;
	logic   rsp_valid;
	logic   rsp_ready = 1'b0;
	rsp_t   rsp;
	logic   cfg_we = 1'b0;
	logic   cfg_index = 1'b0;
	logic [24:0] cfg_data = '0;

	best_fit_heap_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// shadow copy of the allocator state
	logic [24:0] heap_sz;
	logic [7:0]  hdr_sz;
	logic [24:0] seg_start [NSEG];
	logic [24:0] seg_size  [NSEG];
	logic        seg_used  [NSEG];
	int          seg_count;

	rsp_t expected_rsp [$];
	int   errors = 0;
	int   sent = 0;
	int   checked = 0;
	int   cycles = 0;

	// idling knobs in percent
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_rsp = 1'b0;

	// extend to 64 bits before clamping so wide sums are caught
	function automatic logic [24:0] clamp(input logic [63:0] v);
		return (v > 64'(ADDR_SAT)) ? ADDR_SAT : v[24:0];
	endfunction

	function automatic void table_reinit();
		for (int i = 0; i < NSEG; i++) begin
			seg_start[i] = '0;
			seg_size[i]  = '0;
			seg_used[i]  = 1'b0;
		end
		seg_size[0] = (heap_sz > 25'(hdr_sz)) ? clamp(64'(heap_sz) - 64'(hdr_sz)) : '0;
		seg_count = 1;
	endfunction

	function automatic void drop_entry(input int idx);
		for (int i = idx; i + 1 < seg_count; i++) begin
			seg_start[i] = seg_start[i+1];
			seg_size[i]  = seg_size[i+1];
			seg_used[i]  = seg_used[i+1];
		end
		seg_count--;
	endfunction

	function automatic rsp_t allocate_predict(input logic [24:0] nbytes);
		logic [63:0] need;
		logic [63:0] best;
		bit found;
		int pick;
		rsp_t r;
		need = 64'(nbytes) + 64'(hdr_sz);
		best = 64'h7FFFFFFF;
		found = 0;
		pick = 0;
		r = '0;
		for (int i = 0; i < seg_count; i++)
			if (!seg_used[i] && 64'(seg_size[i]) >= need && 64'(seg_size[i]) <= best) begin
				best = 64'(seg_size[i]);
				pick = i;
				found = 1;
			end
		if (!found) begin
			r.status = ST_NOFIT;
			return r;
		end
		if (64'(seg_size[pick]) > need) begin
			if (seg_count >= NSEG) begin
				r.status = ST_FULL;
				return r;
			end
			for (int i = seg_count; i > pick + 1; i--) begin
				seg_start[i] = seg_start[i-1];
				seg_size[i]  = seg_size[i-1];
				seg_used[i]  = seg_used[i-1];
			end
			seg_start[pick+1] = clamp(64'(seg_start[pick]) + 64'(hdr_sz) + 64'(nbytes));
			seg_size[pick+1]  = 25'(64'(seg_size[pick]) - need);
			seg_used[pick+1]  = 1'b0;
			seg_count++;
			seg_size[pick] = nbytes;
		end
		seg_used[pick] = 1'b1;
		r.status  = ST_OK;
		r.address = clamp(64'(seg_start[pick]) + 64'(hdr_sz));
		return r;
	endfunction

	function automatic rsp_t free_predict(input logic [24:0] where);
		int hit;
		int left;
		rsp_t r;
		hit = -1;
		r = '0;
		for (int i = 0; i < seg_count; i++)
			if (clamp(64'(seg_start[i]) + 64'(hdr_sz)) == where) begin
				hit = i;
				break;
			end
		if (hit < 0) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		seg_used[hit] = 1'b0;
		left = hit;
		while (left > 0 && !seg_used[left-1])
			left--;
		// absorb every free neighbor to the right into the run head
		while (left + 1 < seg_count && !seg_used[left+1]) begin
			seg_size[left] = clamp(64'(seg_size[left]) + 64'(seg_size[left+1]) + 64'(hdr_sz));
			drop_entry(left + 1);
		end
		r.status = ST_OK;
		return r;
	endfunction

	function automatic rsp_t heap_predict(input req_t q);
		rsp_t r;
		r = '0;
		case (q.operation)
			OP_ALLOC:  r = allocate_predict(q.request_bytes);
			OP_FREE:   r = free_predict(q.release_address);
			OP_REINIT: table_reinit();
			default:   r = '0;
		endcase
		return r;
	endfunction

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// response side: stall pattern changes at the falling edge
	always @(negedge clk)
		if (arst_n)
			rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_stall);

	// response checker at the rising edge
	always @(posedge clk)
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				$error("response with no request outstanding: status %0d address %0h",
					rsp.status, rsp.address);
				errors++;
			end else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.address !== e.address) begin
					$error("address: expected %0h actual %0h", e.address, rsp.address);
					errors++;
				end
			end
			checked++;
		end

	// one request: optional idle gap, then hold valid until accepted
	task automatic send_request(input req_t q);
		while ($urandom_range(99) < send_idle)
			@(negedge clk);
		req_valid = 1'b1;
		req = q;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		expected_rsp.push_back(heap_predict(q));
		sent++;
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [24:0] nbytes,
		input logic [24:0] where);
		req_t q;
		q.operation = op;
		q.request_bytes = nbytes;
		q.release_address = where;
		send_request(q);
	endtask

	// wait for every response, then let the block settle
	task automatic drain();
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [24:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEAP_BYTES)
			heap_sz = val;
		else
			hdr_sz = val[7:0];
	endtask

	// random addresses that were handed out, to free later
	logic [24:0] live [$];

	task automatic random_phase(input int n, input int small_max);
		rsp_t r;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 45) begin
				send_op(OP_ALLOC, (k < 3) ? 25'($urandom) : 25'($urandom_range(small_max)),
					25'($urandom));
				if (expected_rsp[$].status == ST_OK)
					live.push_back(expected_rsp[$].address);
			end else if (k < 85 && live.size() != 0) begin
				int j;
				j = $urandom_range(live.size() - 1);
				send_op(OP_FREE, 25'($urandom), live[j]);
				live.delete(j);
			end else if (k < 92) begin
				send_op(OP_FREE, 25'($urandom), 25'($urandom));
			end else if (k < 96) begin
				send_op(OP_REINIT, 25'($urandom), 25'($urandom));
				live.delete();
			end else begin
				send_op(2'd3, 25'($urandom), 25'($urandom));
			end
		end
	endtask

	task automatic test_directed();
		send_op(OP_ALLOC, 25'd100, 25'd0);
		send_op(OP_ALLOC, 25'd100, 25'd0);
		send_op(OP_FREE, 25'd0, 25'd16);
		send_op(OP_FREE, 25'd0, 25'd16);          // already free, merge still runs
		send_op(OP_FREE, 25'd0, 25'd12345);       // unknown address
		send_op(OP_ALLOC, ADDR_SAT, 25'd0);       // nothing fits
		send_op(OP_ALLOC, 25'd0, 25'd0);          // zero bytes
		send_op(2'd3, ADDR_SAT, ADDR_SAT);        // unused operation
		send_op(OP_REINIT, 25'd0, 25'd0);
		// fill the table with small blocks until splitting is refused
		for (int i = 0; i < 66; i++)
			send_op(OP_ALLOC, 25'd8, 25'd0);
		// freed hole is smaller than request plus header, so the large tail is picked and the split is refused
		send_op(OP_FREE, 25'd0, 25'd16 + 25'd24);
		send_op(OP_ALLOC, 25'd8, 25'd0);
		send_op(OP_REINIT, 25'd0, 25'd0);
		send_op(OP_ALLOC, 25'(32505856 - 32), 25'd0); // exact fit of the whole heap, no split
		send_op(OP_REINIT, 25'd0, 25'd0);
		drain();
	endtask

	task automatic test_config_sweep();
		// tiny heap, no header
		write_reg(REG_HEAP_BYTES, 25'd32);
		write_reg(REG_HEADER_BYTES, 25'd0);
		send_op(OP_REINIT, 25'd0, 25'd0);
		live.delete();
		random_phase(120, 12);
		// heap smaller than a header saturates to zero size
		write_reg(REG_HEADER_BYTES, 25'd255);
		send_op(OP_REINIT, 25'd0, 25'd0);
		send_op(OP_ALLOC, 25'd0, 25'd0);
		// full heap, largest header
		write_reg(REG_HEAP_BYTES, ADDR_SAT);
		send_op(OP_REINIT, 25'd0, 25'd0);
		live.delete();
		random_phase(120, 500000);
		// header change without reinitialize shifts the data offsets
		write_reg(REG_HEADER_BYTES, 25'd0);
		random_phase(40, 500000);
		write_reg(REG_HEADER_BYTES, 25'd170);
		write_reg(REG_HEAP_BYTES, 25'd4000);
		send_op(OP_REINIT, 25'd0, 25'd0);
		live.delete();
		random_phase(100, 120);
		drain();
	endtask

	task automatic test_idling();
		write_reg(REG_HEAP_BYTES, 25'd20000);
		write_reg(REG_HEADER_BYTES, 25'd16);
		send_op(OP_REINIT, 25'd0, 25'd0);
		live.delete();
		send_idle = 80; recv_stall = 0;
		random_phase(100, 600);
		send_idle = 0; recv_stall = 80;
		random_phase(100, 600);
		send_idle = 15; recv_stall = 15;
		random_phase(150, 600);
		send_idle = 0; recv_stall = 0;
		drain();
	endtask

	task automatic test_backpressure();
		// receiver holds off while requests keep coming
		fork
			begin
				hold_rsp = 1'b1;
				for (int c = 0; c < 2000; c++)
					@(negedge clk);
				hold_rsp = 1'b0;
			end
			random_phase(30, 600);
		join
		drain();
		random_phase(120, 600);
		drain();
	endtask

	initial begin
		heap_sz = HEAP_RESET;
		hdr_sz = HEADER_RESET;
		table_reinit();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config_sweep();
		test_idling();
		test_backpressure();
		drain();
		$display("covered %0d requests, %0d responses checked, across several heap and",
			sent, checked);
		$display("header settings with sender gaps, receiver stalls and a long hold-off");
		if (errors == 0 && expected_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
